@@ src/tfbs_pkg.sv @@
// Shared types, constants and the tile marker encoder of the feedback bitmap scanner.
// Used by the front end, queue, back end and top level of the scanner; depends on nothing else.
package tfbs_pkg;

   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned INDEX_BITS  = 8;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned GROUP_COUNT = 6;

   localparam logic [7:0] POS_IDLE    = 8'd0;
   localparam logic [7:0] POS_HEADER1 = 8'd1;
   localparam logic [7:0] POS_DATA0   = 8'd2;
   localparam logic [7:0] POS_DONE    = 8'd173;
   localparam logic [7:0] TAIL_INDEX  = 8'd170;
   localparam logic [31:0] TAIL_MASK  = 32'h0FFF_FFFF;

   typedef struct packed {
      logic [WORD_BITS-1:0]  mask;
      logic [INDEX_BITS-1:0] index;
   } q_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic [15:0] marker_of(logic [12:0] off);
      logic [3:0]  mip;
      logic [12:0] base;
      logic [11:0] inner;
      logic [5:0]  tx;
      logic [5:0]  ty;
      if (off < 13'd12) begin
         mip = 4'd5;
         base = 13'd8;
      end else if (off < 13'd28) begin
         mip = 4'd4;
         base = 13'd12;
      end else if (off < 13'd92) begin
         mip = 4'd3;
         base = 13'd28;
      end else if (off < 13'd348) begin
         mip = 4'd2;
         base = 13'd92;
      end else if (off < 13'd1372) begin
         mip = 4'd1;
         base = 13'd348;
      end else begin
         mip = 4'd0;
         base = 13'd1372;
      end
      inner = 12'(off - base);
      case (mip)
         4'd5: begin
            tx = {5'd0, inner[0]};
            ty = {5'd0, inner[1]};
         end
         4'd4: begin
            tx = {4'd0, inner[1:0]};
            ty = {4'd0, inner[3:2]};
         end
         4'd3: begin
            tx = {3'd0, inner[2:0]};
            ty = {3'd0, inner[5:3]};
         end
         4'd2: begin
            tx = {2'd0, inner[3:0]};
            ty = {2'd0, inner[7:4]};
         end
         4'd1: begin
            tx = {1'd0, inner[4:0]};
            ty = {1'd0, inner[9:5]};
         end
         default: begin
            tx = inner[5:0];
            ty = inner[11:6];
         end
      endcase
      if (off < 13'd8) begin
         return {4'(4'd13 - off[3:0]), 12'd0};
      end
      return {mip, ty, tx};
   endfunction

endpackage

@@ src/tfbs_front.sv @@
// Front end of the feedback bitmap scanner: takes input words, tracks the header and
// the word position, and queues the eligible decision bits of each data word. Uses tfbs_pkg.
module tfbs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [31:0]          req_word,
   input  logic                 req_start_req,
   input  tfbs_pkg::q_status_type q_status,
   output logic                 q_push,
   output tfbs_pkg::q_entry_type  q_entry
);
   import tfbs_pkg::*;

   logic [GROUP_COUNT-1:0] group_active_ff, group_active_in;
   logic [7:0]             patch_active_ff [GROUP_COUNT];
   logic [7:0]             patch_active_in [GROUP_COUNT];
   logic [7:0]             word_position_ff, word_position_in;
   logic                   accept;
   logic                   is_data;
   logic [INDEX_BITS-1:0]  index;
   logic [2:0]             grp;
   logic [2:0]             pat;
   logic                   enabled;
   logic [WORD_BITS-1:0]   mask;

   assign req_full = q_status.full;
   assign accept   = req_push && !req_full;
   assign index    = INDEX_BITS'(word_position_ff - POS_DATA0);
   assign grp      = index[7:5];
   assign pat      = index[4:2];
   assign is_data  = !req_start_req && (word_position_ff >= POS_DATA0)
                     && (word_position_ff < POS_DONE);
   assign enabled  = group_active_ff[grp] && patch_active_ff[grp][pat];
   assign mask     = (index == TAIL_INDEX) ? (req_word & TAIL_MASK) : req_word;

   assign q_push        = accept && is_data && enabled && (mask != '0);
   assign q_entry.mask  = mask;
   assign q_entry.index = index;

   always_comb begin
      group_active_in  = group_active_ff;
      patch_active_in  = patch_active_ff;
      word_position_in = word_position_ff;
      if (accept) begin
         if (req_start_req) begin
            group_active_in    = req_word[5:0];
            patch_active_in[0] = req_word[15:8];
            patch_active_in[1] = req_word[23:16];
            patch_active_in[2] = req_word[31:24];
            word_position_in   = POS_HEADER1;
         end else if (word_position_ff == POS_HEADER1) begin
            patch_active_in[3] = req_word[7:0];
            patch_active_in[4] = req_word[15:8];
            patch_active_in[5] = req_word[23:16];
            word_position_in   = POS_DATA0;
         end else if (is_data) begin
            word_position_in = word_position_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_active_ff  <= '0;
         word_position_ff <= POS_IDLE;
         for (int g = 0; g < GROUP_COUNT; g++) begin
            patch_active_ff[g] <= '0;
         end
      end else begin
         group_active_ff  <= group_active_in;
         word_position_ff <= word_position_in;
         patch_active_ff  <= patch_active_in;
      end
   end

endmodule

@@ src/tfbs_queue.sv @@
// Short queue of pending data words between the front and back ends of the scanner.
// Uses tfbs_pkg for the entry and status types.
module tfbs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tfbs_pkg::q_entry_type  push_entry,
   input  logic                   pop,
   output tfbs_pkg::q_entry_type  head_entry,
   output tfbs_pkg::q_status_type status
);
   import tfbs_pkg::*;

   q_entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ src/tfbs_back.sv @@
// Back end of the feedback bitmap scanner (tfbs_pkg): walks set bits of a queued word,
// lowest first, one tile marker per cycle into the result register if free or popped.
module tfbs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tfbs_pkg::q_entry_type  q_entry,
   input  tfbs_pkg::q_status_type q_status,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [15:0]            rsp_tile_marker,
   output logic                   rsp_last
);
   import tfbs_pkg::*;

   logic [WORD_BITS-1:0]  mask_ff, mask_in;
   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic                  busy_ff, busy_in;
   logic                  out_valid_ff, out_valid_in;
   logic [15:0]           marker_ff, marker_in;
   logic                  last_ff, last_in;
   logic [4:0]            bit_idx;
   logic [WORD_BITS-1:0]  rest;
   logic                  emit;

   assign rsp_empty       = !out_valid_ff;
   assign rsp_tile_marker = marker_ff;
   assign rsp_last        = last_ff;
   assign rest            = mask_ff & (mask_ff - 32'd1);
   assign emit            = busy_ff && (!out_valid_ff || rsp_pop);
   assign q_pop           = !busy_ff && !q_status.empty;

   always_comb begin
      bit_idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (mask_ff[b]) begin
            bit_idx = 5'(b);
         end
      end
   end

   always_comb begin
      mask_in      = mask_ff;
      index_in     = index_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      marker_in    = marker_ff;
      last_in      = last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         marker_in    = marker_of({index_ff, bit_idx});
         last_in      = (rest == '0);
         mask_in      = rest;
         busy_in      = (rest != '0);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (q_pop) begin
         mask_in  = q_entry.mask;
         index_in = q_entry.index;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff   <= mask_in;
      index_ff  <= index_in;
      marker_ff <= marker_in;
      last_ff   <= last_in;
   end

endmodule

@@ src/tile_feedback_bitmap_scanner_unit.sv @@
// Top level of the feedback bitmap scanner: front end, word queue and back end.
// Uses tfbs_pkg, tfbs_front, tfbs_queue and tfbs_back.
// An input word is taken every cycle while the four-entry word queue has room.
// The first marker of a data word passes the word queue, the back end's mask register
// and the result register; the back end then emits one marker per cycle while the result
// register is free or popped. Header words and empty data words are not queued.
// Synchronous reset empties the queue and result register and clears the activity masks.
module tile_feedback_bitmap_scanner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_word,
   input  logic        req_start_req,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_tile_marker,
   output logic        rsp_last
);
   import tfbs_pkg::*;

   q_status_type q_status;
   q_entry_type  push_entry;
   q_entry_type  head_entry;
   logic         q_push;
   logic         q_pop;

   tfbs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_word      (req_word),
      .req_start_req (req_start_req),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   tfbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   tfbs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_entry         (head_entry),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_tile_marker (rsp_tile_marker),
      .rsp_last        (rsp_last)
   );

endmodule

@@ src/tfbs_checker.sv @@
// Port-level checks of the feedback bitmap scanner, bound to its top level.
// Depends on tile_feedback_bitmap_scanner_unit only through its ports.
module tfbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_tile_marker,
   input logic        rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("Result register not empty after reset.");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("Input side full after reset.");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_tile_marker)
      && $stable(rsp_last)))
      else $error("Waiting result changed before its transaction.");

   a_mip_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_tile_marker[15:12] <= 4'd13))
      else $error("Tile marker carries a mip level above thirteen.");

   a_coarse_mip_origin: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_tile_marker[15:12] >= 4'd6)) |-> (rsp_tile_marker[11:0] == 12'd0))
      else $error("Single-tile mip level has a nonzero tile position.");

endmodule

bind tile_feedback_bitmap_scanner_unit tfbs_checker u_tfbs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_tile_marker (rsp_tile_marker),
   .rsp_last        (rsp_last)
);
